// ----- sv/edsd_pkg.sv -----
// Shared types, constants and codes for the escaped delta sample decoder.
package edsd_pkg;

    // Default internal sample counter width
    localparam int COUNT_WIDTH_DEF = 24;

    // Field widths fixed by the interface
    localparam int DONE_W   = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BYTES    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_METHOD       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 2'd3;

    // Configuration reset values
    localparam logic [23:0] FRAME_LENGTH_RST = 24'd1024;
    localparam logic [2:0]  MAX_BYTES_RST    = 3'd4;
    localparam logic        METHOD_RST       = 1'b0;
    localparam logic [31:0] GAIN_RST         = 32'h0001_0000;

    // Code sizes and methods
    localparam logic [2:0] MODE_ABS16  = 3'd2;
    localparam logic [2:0] MODE_FULL32 = 3'd4;
    localparam logic       METHOD_W32  = 1'b0;

    // Escape codes
    localparam logic [7:0]  ESC_BYTE = 8'h7F;
    localparam logic [15:0] ESC_WORD = 16'h7FFF;

    // Result kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // Frame status codes
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_UNUSED = 2'd1;
    localparam logic [1:0] STATUS_SHORT  = 2'd2;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Decode phase, one-hot
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_W16  = 4'b0010,
        PH_W32  = 4'b0100,
        PH_W24  = 4'b1000
    } phase_t;

    // Settings the front end needs for decoding
    typedef struct packed {
        logic [23:0] frame_length;
        logic [2:0]  max_bytes_mode;
        logic        method_select;
    } dec_cfg_t;

    // One decoded event: a sample, a report, or both
    typedef struct packed {
        logic              has_sample;
        logic              has_report;
        logic [31:0]       raw;
        logic [DONE_W-1:0] done;
        logic [1:0]        status;
        logic [31:0]       unused;
    } ev_t;

endpackage

// ----- sv/edsd_front.sv -----
// Front end: byte decoding phase machine, accumulator and frame bookkeeping.
module edsd_front #(
    parameter int COUNT_WIDTH = edsd_pkg::COUNT_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    input  edsd_pkg::dec_cfg_t cfg,
    output logic               push,
    output edsd_pkg::ev_t      ev
);
    import edsd_pkg::*;

    logic [31:0]            acc_reg, acc_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    phase_t                 ph_reg, ph_next;
    logic [31:0]            col_reg, col_next;
    logic [2:0]             ncol_reg, ncol_next;
    logic [31:0]            left_reg, left_next;

    logic                   emit;
    logic                   frame_full;
    logic [31:0]            col_ins;
    logic [2:0]             ncol_inc;
    logic [31:0]            word_sx;
    logic [31:0]            v24_sx;
    logic [1:0]             status;

    // Byte placed into the collector at the current byte position
    assign col_ins    = col_reg | (32'(data_byte) << {ncol_reg[1:0], 3'b000});
    assign ncol_inc   = ncol_reg + 3'd1;
    assign word_sx    = {{16{col_ins[15]}}, col_ins[15:0]};
    assign v24_sx     = {{8{col_ins[23]}}, col_ins[23:0]};
    assign frame_full = 32'(cnt_reg) >= 32'(cfg.frame_length);

    // Decode one byte
    always_comb
    begin
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        ph_next   = ph_reg;
        col_next  = col_reg;
        ncol_next = ncol_reg;
        left_next = left_reg;
        emit      = 1'b0;
        case (ph_reg)
            PH_IDLE:
            begin
                if (frame_full)
                begin
                    if (left_reg != '1)
                    begin
                        left_next = left_reg + 32'd1;
                    end
                end
                else if (data_byte != ESC_BYTE)
                begin
                    acc_next = acc_reg + {{24{data_byte[7]}}, data_byte};
                    emit     = 1'b1;
                end
                else
                begin
                    ph_next   = PH_W16;
                    col_next  = '0;
                    ncol_next = '0;
                end
            end
            PH_W16:
            begin
                col_next  = col_ins;
                ncol_next = ncol_inc;
                if (ncol_inc >= 3'd2)
                begin
                    col_next  = '0;
                    ncol_next = '0;
                    if (cfg.max_bytes_mode == MODE_ABS16)
                    begin
                        acc_next = word_sx;
                        ph_next  = PH_IDLE;
                        emit     = 1'b1;
                    end
                    else if (col_ins[15:0] != ESC_WORD)
                    begin
                        acc_next = acc_reg + word_sx;
                        ph_next  = PH_IDLE;
                        emit     = 1'b1;
                    end
                    else if (cfg.method_select == METHOD_W32 ||
                             cfg.max_bytes_mode == MODE_FULL32)
                    begin
                        ph_next = PH_W32;
                    end
                    else
                    begin
                        ph_next = PH_W24;
                    end
                end
            end
            PH_W32:
            begin
                col_next  = col_ins;
                ncol_next = ncol_inc;
                if (ncol_inc >= 3'd4)
                begin
                    acc_next  = col_ins;
                    ph_next   = PH_IDLE;
                    col_next  = '0;
                    ncol_next = '0;
                    emit      = 1'b1;
                end
            end
            PH_W24:
            begin
                col_next  = col_ins;
                ncol_next = ncol_inc;
                if (ncol_inc >= 3'd3)
                begin
                    acc_next  = v24_sx;
                    ph_next   = PH_IDLE;
                    col_next  = '0;
                    ncol_next = '0;
                    emit      = 1'b1;
                end
            end
            default:
            begin
                ph_next   = PH_IDLE;
                col_next  = '0;
                ncol_next = '0;
            end
        endcase
        // The sample counter saturates
        if (emit && cnt_reg != '1)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    // End-of-frame status from the state after this byte
    always_comb
    begin
        if (ph_next != PH_IDLE || 32'(cnt_next) < 32'(cfg.frame_length))
        begin
            status = STATUS_SHORT;
        end
        else if (left_next != '0)
        begin
            status = STATUS_UNUSED;
        end
        else
        begin
            status = STATUS_OK;
        end
    end

    // Event handed to the queue
    always_comb
    begin
        ev.has_sample = emit;
        ev.has_report = last_byte;
        ev.raw        = acc_next;
        ev.done       = DONE_W'(cnt_next);
        ev.status     = status;
        ev.unused     = left_next;
    end

    assign push = accept && (emit || last_byte);

    // State update; the last byte returns the frame state to reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            cnt_reg  <= '0;
            ph_reg   <= PH_IDLE;
            col_reg  <= '0;
            ncol_reg <= '0;
            left_reg <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                acc_reg  <= '0;
                cnt_reg  <= '0;
                ph_reg   <= PH_IDLE;
                col_reg  <= '0;
                ncol_reg <= '0;
                left_reg <= '0;
            end
            else
            begin
                acc_reg  <= acc_next;
                cnt_reg  <= cnt_next;
                ph_reg   <= ph_next;
                col_reg  <= col_next;
                ncol_reg <= ncol_next;
                left_reg <= left_next;
            end
        end
    end

endmodule

// ----- sv/edsd_queue.sv -----
// Short event queue between the decoding front end and the output back end.
module edsd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  edsd_pkg::ev_t push_ev,
    input  logic          pop,
    output logic          full,
    output logic          not_empty,
    output edsd_pkg::ev_t head
);
    import edsd_pkg::*;

    ev_t               mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg;
    logic [QPTR_W-1:0] rd_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign full      = cnt_reg == QCNT_W'(QUEUE_DEPTH);
    assign not_empty = cnt_reg != '0;
    assign head      = mem[rd_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_ev;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ----- sv/edsd_back.sv -----
// Back end: gain multiply stage and output register, one result item per cycle while out_stall is low.
module edsd_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  edsd_pkg::ev_t               head,
    input  logic [31:0]                 gain_q16,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        item_kind,
    output logic signed [31:0]          raw_value,
    output logic signed [63:0]          scaled_value,
    output logic [1:0]                  frame_status,
    output logic [31:0]                 unused_count,
    output logic [edsd_pkg::DONE_W-1:0] samples_done,
    output logic                        run_last
);
    import edsd_pkg::*;

    logic               m_valid_reg;
    ev_t                m_ev_reg;
    logic signed [63:0] m_prod_reg;
    logic               m_sample_reg;

    logic               o_valid_reg;
    logic               o_kind_reg;
    logic [31:0]        o_raw_reg;
    logic [63:0]        o_scaled_reg;
    logic [1:0]         o_status_reg;
    logic [31:0]        o_unused_reg;
    logic [DONE_W-1:0]  o_done_reg;
    logic               o_last_reg;

    logic               o_free;
    logic               issue;
    logic               finish;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] mul_p;

    assign mul_a = head.raw;
    assign mul_b = gain_q16;
    assign mul_p = mul_a * mul_b;

    // Handshake between the multiply stage and the output register
    assign o_free = !o_valid_reg || !out_stall;
    assign issue  = m_valid_reg && o_free;
    assign finish = issue && (!m_sample_reg || !m_ev_reg.has_report);
    assign pop    = q_valid && (!m_valid_reg || finish);

    // Multiply stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg  <= 1'b0;
            m_sample_reg <= 1'b0;
        end
        else if (pop)
        begin
            m_valid_reg  <= 1'b1;
            m_sample_reg <= head.has_sample;
        end
        else if (finish)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (issue)
        begin
            m_sample_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            m_ev_reg   <= head;
            m_prod_reg <= mul_p;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (issue)
        begin
            o_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            o_valid_reg <= 1'b0;
        end
    end

    // Output payload: the sample goes out before the report
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            o_done_reg <= m_ev_reg.done;
            if (m_sample_reg)
            begin
                o_kind_reg   <= KIND_SAMPLE;
                o_raw_reg    <= m_ev_reg.raw;
                o_scaled_reg <= m_prod_reg;
                o_status_reg <= STATUS_OK;
                o_unused_reg <= '0;
                o_last_reg   <= !m_ev_reg.has_report;
            end
            else
            begin
                o_kind_reg   <= KIND_REPORT;
                o_raw_reg    <= '0;
                o_scaled_reg <= '0;
                o_status_reg <= m_ev_reg.status;
                o_unused_reg <= m_ev_reg.unused;
                o_last_reg   <= 1'b1;
            end
        end
    end

    assign out_valid    = o_valid_reg;
    assign item_kind    = o_kind_reg;
    assign raw_value    = o_raw_reg;
    assign scaled_value = o_scaled_reg;
    assign frame_status = o_status_reg;
    assign unused_count = o_unused_reg;
    assign samples_done = o_done_reg;
    assign run_last     = o_last_reg;

endmodule

// ----- sv/escaped_delta_sample_decoder_unit.sv -----
// Escaped delta sample decoder: top level with configuration registers.
//
//   Channel   Handshake               Payload
//   input     in_valid / in_stall     data_byte, last_byte
//   output    out_valid / out_stall   item_kind, raw_value, scaled_value, frame_status,
//                                     unused_count, samples_done, run_last
//   config    cfg_write               cfg_index, cfg_data
//
// One byte is accepted per cycle while the four-entry event queue has room.
// A byte that yields one result passes through the queue, the multiply stage register and
// the output register; a byte with both a sample and a report yields the sample, then the report.
// The output register holds the item while out_stall is high; reset is
// asynchronous and restores the registers and frame state to their defaults.
module escaped_delta_sample_decoder_unit #(
    parameter int COUNT_WIDTH = edsd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      data_byte,
    input  logic                            last_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            item_kind,
    output logic signed [31:0]              raw_value,
    output logic signed [63:0]              scaled_value,
    output logic [1:0]                      frame_status,
    output logic [31:0]                     unused_count,
    output logic [edsd_pkg::DONE_W-1:0]     samples_done,
    output logic                            run_last,
    input  logic                            cfg_write,
    input  logic [edsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [edsd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import edsd_pkg::*;

    logic [23:0] frame_length_reg;
    logic [2:0]  max_bytes_reg;
    logic        method_reg;
    logic [31:0] gain_reg;

    dec_cfg_t    dec_cfg;
    logic        accept;
    logic        push;
    ev_t         push_ev;
    logic        pop;
    logic        q_full;
    logic        q_valid;
    ev_t         q_head;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg <= FRAME_LENGTH_RST;
            max_bytes_reg    <= MAX_BYTES_RST;
            method_reg       <= METHOD_RST;
            gain_reg         <= GAIN_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FRAME_LENGTH: frame_length_reg <= cfg_data[23:0];
                REG_MAX_BYTES:    max_bytes_reg    <= cfg_data[2:0];
                REG_METHOD:       method_reg       <= cfg_data[0];
                REG_GAIN:         gain_reg         <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign dec_cfg.frame_length   = frame_length_reg;
    assign dec_cfg.max_bytes_mode = max_bytes_reg;
    assign dec_cfg.method_select  = method_reg;

    // Input handshake
    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    edsd_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .cfg       (dec_cfg),
        .push      (push),
        .ev        (push_ev)
    );

    edsd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_ev   (push_ev),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (q_head)
    );

    edsd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .head         (q_head),
        .gain_q16     (gain_reg),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .item_kind    (item_kind),
        .raw_value    (raw_value),
        .scaled_value (scaled_value),
        .frame_status (frame_status),
        .unused_count (unused_count),
        .samples_done (samples_done),
        .run_last     (run_last)
    );

endmodule
